// ----- hdl/lpkc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpkc_pkg: shared types and constants of the link packet kind classifier
// Beat structs, framing classes, register indexes and the magic prefix.
// ----------------------------------------------------------------------------
package lpkc_pkg;

   // Input beat: one payload byte with its port and end-of-packet mark
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] dest_port;
      logic        last_byte;
   } req_type;

   // Result beat: one per packet
   typedef struct packed {
      logic [5:0] packet_kind;
      logic [7:0] device_number;
      logic       number_valid;
      logic       magic_match;
   } rsp_type;

   // Framing class selected by the destination port
   typedef enum logic [2:0] {
      CLASS_NONE     = 3'd0,
      CLASS_ANNOUNCE = 3'd1,
      CLASS_BEAT     = 3'd2,
      CLASS_STATUS   = 3'd3,
      CLASS_AUDIO    = 3'd4
   } class_type;

   // Configuration register indexes
   localparam logic [7:0] CSR_ANNOUNCE_PORT = 8'd0;
   localparam logic [7:0] CSR_BEAT_PORT     = 8'd1;
   localparam logic [7:0] CSR_STATUS_PORT   = 8'd2;
   localparam logic [7:0] CSR_AUDIO_PORT    = 8'd3;

   // Register reset values
   localparam logic [15:0] ANNOUNCE_PORT_RESET = 16'd50000;
   localparam logic [15:0] BEAT_PORT_RESET     = 16'd50001;
   localparam logic [15:0] STATUS_PORT_RESET   = 16'd50002;
   localparam logic [15:0] AUDIO_PORT_RESET    = 16'd0;

   // Byte offsets within the payload
   localparam int unsigned PREFIX_LEN = 10;
   localparam logic [5:0] KIND_AT         = 6'h0a;
   localparam logic [5:0] NUM_AT_ANNOUNCE = 6'h24;
   localparam logic [5:0] NUM_AT_OTHER    = 6'h21;
   localparam logic [5:0] POS_LIMIT       = 6'd37;
   localparam logic [5:0] PREFIX_END      = 6'(PREFIX_LEN);

   localparam logic [5:0] KIND_UNKNOWN = 6'd0;

   // Magic prefix expected at offsets 0 to 9
   typedef logic [7:0] prefix_array_type [PREFIX_LEN];
   localparam prefix_array_type PREFIX_BYTES = '{
      8'h51, 8'h73, 8'h70, 8'h74, 8'h31, 8'h57, 8'h6d, 8'h4a, 8'h4f, 8'h4c
   };

endpackage

// ----- hdl/link_packet_kind_classifier_top.sv -----
// ----------------------------------------------------------------------------
// link_packet_kind_classifier_top: packet kind classifier for a UDP link
// Checks the magic prefix, captures kind and device number bytes and
// reports one result beat per packet.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one payload byte per beat (req_data), with the destination
//    port (used on the first byte of a packet) and a last-byte mark.
//  - rsp channel: one result beat per packet, issued for the last byte.
//  - csr channel: port register writes, always ready (csr_ready high).
//    Index 0 announce, 1 beat, 2 status, 3 audio; other indexes are ignored.
// Timing:
//  - One byte per cycle while req_stall is low; the packet state is updated in the
//    accepting cycle and the result loads into the output register at the
//    edge that accepts the last byte, so rsp_valid rises in the next cycle.
//  - A waiting result does not block non-stop flow: req_stall rises only
//    while the output register holds a beat and rsp_stall is high.
// Reset:
//  - Synchronous reset loads the default port registers, clears the packet
//    state and empties the output register.
// ----------------------------------------------------------------------------
module link_packet_kind_classifier_top (
   input  logic              clock,
   input  logic              reset,
   // input beats
   input  logic              req_valid,
   output logic              req_stall,
   input  lpkc_pkg::req_type req_data,
   // result beats
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpkc_pkg::rsp_type rsp_data,
   // configuration writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_data
);

   // Port registers
   logic [15:0] announce_port_ff, beat_port_ff, status_port_ff, audio_port_ff;

   // Packet state
   logic [5:0]          pos_ff, pos_in;
   logic                magic_ff, magic_in;
   lpkc_pkg::class_type class_ff, class_in;
   logic [7:0]          kind_val_ff, kind_val_in;
   logic                kind_cap_ff, kind_cap_in;
   logic [7:0]          num_val_ff, num_val_in;
   logic                num_cap_ff, num_cap_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   lpkc_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                req_accept;
   lpkc_pkg::class_type port_class;
   logic [5:0]          num_at;
   logic [5:0]          count;
   logic                magic_ok;
   logic [5:0]          decoded_kind;

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Write port registers
   always_ff @(posedge clock) begin
      if (reset) begin
         announce_port_ff <= lpkc_pkg::ANNOUNCE_PORT_RESET;
         beat_port_ff     <= lpkc_pkg::BEAT_PORT_RESET;
         status_port_ff   <= lpkc_pkg::STATUS_PORT_RESET;
         audio_port_ff    <= lpkc_pkg::AUDIO_PORT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lpkc_pkg::CSR_ANNOUNCE_PORT: announce_port_ff <= csr_data;
            lpkc_pkg::CSR_BEAT_PORT:     beat_port_ff     <= csr_data;
            lpkc_pkg::CSR_STATUS_PORT:   status_port_ff   <= csr_data;
            lpkc_pkg::CSR_AUDIO_PORT:    audio_port_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Match the destination port, announce first
   always_comb begin
      if (req_data.dest_port == announce_port_ff) begin
         port_class = lpkc_pkg::CLASS_ANNOUNCE;
      end else if (req_data.dest_port == beat_port_ff) begin
         port_class = lpkc_pkg::CLASS_BEAT;
      end else if (req_data.dest_port == status_port_ff) begin
         port_class = lpkc_pkg::CLASS_STATUS;
      end else if (req_data.dest_port == audio_port_ff) begin
         port_class = lpkc_pkg::CLASS_AUDIO;
      end else begin
         port_class = lpkc_pkg::CLASS_NONE;
      end
   end

   // Advance packet state for the current byte
   always_comb begin
      class_in    = (pos_ff == 6'd0) ? port_class : class_ff;
      magic_in    = magic_ff;
      kind_val_in = kind_val_ff;
      kind_cap_in = kind_cap_ff;
      num_val_in  = num_val_ff;
      num_cap_in  = num_cap_ff;
      if (pos_ff < lpkc_pkg::PREFIX_END &&
          req_data.data_byte != lpkc_pkg::PREFIX_BYTES[pos_ff[3:0]]) begin
         magic_in = 1'b0;
      end
      if (pos_ff == lpkc_pkg::KIND_AT) begin
         kind_val_in = req_data.data_byte;
         kind_cap_in = 1'b1;
      end
      num_at = (class_in == lpkc_pkg::CLASS_ANNOUNCE) ? lpkc_pkg::NUM_AT_ANNOUNCE
                                                      : lpkc_pkg::NUM_AT_OTHER;
      if (pos_ff == num_at) begin
         num_val_in = req_data.data_byte;
         num_cap_in = 1'b1;
      end
      count    = (pos_ff >= lpkc_pkg::POS_LIMIT) ? lpkc_pkg::POS_LIMIT : pos_ff + 6'd1;
      pos_in   = count;
      magic_ok = magic_in && (count >= lpkc_pkg::PREFIX_END);
   end

   lpkc_kind_decode u_kind_decode (
      .kind_class  (class_in),
      .kind_byte   (kind_val_in),
      .packet_kind (decoded_kind)
   );

   // Build the result beat for the last byte
   always_comb begin
      rsp_data_in.packet_kind   = (magic_ok && kind_cap_in) ? decoded_kind
                                                            : lpkc_pkg::KIND_UNKNOWN;
      rsp_data_in.device_number = num_cap_in ? num_val_in : 8'd0;
      rsp_data_in.number_valid  = num_cap_in;
      rsp_data_in.magic_match   = magic_ok;
      if (req_accept && req_data.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold packet state; clear it after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 6'd0;
         magic_ff    <= 1'b1;
         class_ff    <= lpkc_pkg::CLASS_NONE;
         kind_val_ff <= 8'd0;
         kind_cap_ff <= 1'b0;
         num_val_ff  <= 8'd0;
         num_cap_ff  <= 1'b0;
      end else if (req_accept) begin
         if (req_data.last_byte) begin
            pos_ff      <= 6'd0;
            magic_ff    <= 1'b1;
            class_ff    <= lpkc_pkg::CLASS_NONE;
            kind_val_ff <= 8'd0;
            kind_cap_ff <= 1'b0;
            num_val_ff  <= 8'd0;
            num_cap_ff  <= 1'b0;
         end else begin
            pos_ff      <= pos_in;
            magic_ff    <= magic_in;
            class_ff    <= class_in;
            kind_val_ff <= kind_val_in;
            kind_cap_ff <= kind_cap_in;
            num_val_ff  <= num_val_in;
            num_cap_ff  <= num_cap_in;
         end
      end
   end

   // Output register: load on a last byte, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_data.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- hdl/lpkc_kind_decode.sv -----
// ----------------------------------------------------------------------------
// lpkc_kind_decode: kind byte to packet kind number
// Maps the framing class and the captured kind byte to kinds 1 to 33.
// ----------------------------------------------------------------------------
module lpkc_kind_decode (
   input  lpkc_pkg::class_type kind_class,
   input  logic [7:0]          kind_byte,
   output logic [5:0]          packet_kind
);

   // Look up the kind within the class table
   always_comb begin
      packet_kind = lpkc_pkg::KIND_UNKNOWN;
      case (kind_class)
         lpkc_pkg::CLASS_ANNOUNCE: begin
            case (kind_byte)
               8'h00:   packet_kind = 6'd1;
               8'h01:   packet_kind = 6'd2;
               8'h02:   packet_kind = 6'd3;
               8'h03:   packet_kind = 6'd4;
               8'h04:   packet_kind = 6'd5;
               8'h05:   packet_kind = 6'd6;
               8'h06:   packet_kind = 6'd7;
               8'h08:   packet_kind = 6'd8;
               8'h0a:   packet_kind = 6'd9;
               default: packet_kind = lpkc_pkg::KIND_UNKNOWN;
            endcase
         end
         lpkc_pkg::CLASS_BEAT: begin
            case (kind_byte)
               8'h02:   packet_kind = 6'd10;
               8'h03:   packet_kind = 6'd11;
               8'h0b:   packet_kind = 6'd12;
               8'h26:   packet_kind = 6'd13;
               8'h27:   packet_kind = 6'd14;
               8'h28:   packet_kind = 6'd15;
               8'h2a:   packet_kind = 6'd16;
               8'h6a:   packet_kind = 6'd17;
               default: packet_kind = lpkc_pkg::KIND_UNKNOWN;
            endcase
         end
         lpkc_pkg::CLASS_STATUS: begin
            case (kind_byte)
               8'h05:   packet_kind = 6'd18;
               8'h06:   packet_kind = 6'd19;
               8'h0a:   packet_kind = 6'd20;
               8'h10:   packet_kind = 6'd21;
               8'h19:   packet_kind = 6'd22;
               8'h1a:   packet_kind = 6'd23;
               8'h29:   packet_kind = 6'd24;
               8'h34:   packet_kind = 6'd25;
               8'h39:   packet_kind = 6'd26;
               8'h40:   packet_kind = 6'd27;
               8'h55:   packet_kind = 6'd28;
               8'h56:   packet_kind = 6'd29;
               8'h58:   packet_kind = 6'd30;
               default: packet_kind = lpkc_pkg::KIND_UNKNOWN;
            endcase
         end
         lpkc_pkg::CLASS_AUDIO: begin
            case (kind_byte)
               8'h1e:   packet_kind = 6'd31;
               8'h1f:   packet_kind = 6'd32;
               8'h20:   packet_kind = 6'd33;
               default: packet_kind = lpkc_pkg::KIND_UNKNOWN;
            endcase
         end
         default: packet_kind = lpkc_pkg::KIND_UNKNOWN;
      endcase
   end

endmodule

// ----- tb/lpkc_kind_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpkc_kind_checker: result predictor and scoreboard for the kind classifier
// Tracks port register writes and every accepted payload beat, works out the
// result each packet should give, and compares the result beats in order.
// ----------------------------------------------------------------------------
module lpkc_kind_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  lpkc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  lpkc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [15:0]       csr_data,
   output int                mismatch_count,
   output int                outstanding
);

   // First packet kind number of each framing class
   localparam logic [5:0] ANNOUNCE_BASE = 6'd1;
   localparam logic [5:0] BEAT_BASE     = 6'd10;
   localparam logic [5:0] STATUS_BASE   = 6'd18;
   localparam logic [5:0] AUDIO_BASE    = 6'd31;

   // Kind bytes recognized per class, in kind number order
   localparam logic [0:8][7:0] ANNOUNCE_KINDS = {
      8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h08, 8'h0a
   };
   localparam logic [0:7][7:0] BEAT_KINDS = {
      8'h02, 8'h03, 8'h0b, 8'h26, 8'h27, 8'h28, 8'h2a, 8'h6a
   };
   localparam logic [0:12][7:0] STATUS_KINDS = {
      8'h05, 8'h06, 8'h0a, 8'h10, 8'h19, 8'h1a, 8'h29, 8'h34, 8'h39, 8'h40,
      8'h55, 8'h56, 8'h58
   };
   localparam logic [0:2][7:0] AUDIO_KINDS = {8'h1e, 8'h1f, 8'h20};

   logic [15:0] announce_port, beat_port, status_port, audio_port;

   // Per-packet state
   logic [5:0]          byte_count;
   logic                prefix_ok;
   lpkc_pkg::class_type frame_class;
   logic [7:0]          kind_byte;
   logic                kind_seen;
   logic [7:0]          device_byte;
   logic                device_seen;

   lpkc_pkg::rsp_type   expected_results[$];
   lpkc_pkg::rsp_type   wanted;

   function automatic lpkc_pkg::class_type class_for(logic [15:0] port);
      if (port == announce_port) return lpkc_pkg::CLASS_ANNOUNCE;
      if (port == beat_port) return lpkc_pkg::CLASS_BEAT;
      if (port == status_port) return lpkc_pkg::CLASS_STATUS;
      if (port == audio_port) return lpkc_pkg::CLASS_AUDIO;
      return lpkc_pkg::CLASS_NONE;
   endfunction

   function automatic logic [5:0] kind_for(lpkc_pkg::class_type cls, logic [7:0] value);
      logic [5:0] code;
      code = lpkc_pkg::KIND_UNKNOWN;
      case (cls)
         lpkc_pkg::CLASS_ANNOUNCE: begin
            for (int i = 0; i < 9; i++)
               if (ANNOUNCE_KINDS[i] == value) code = ANNOUNCE_BASE + 6'(i);
         end
         lpkc_pkg::CLASS_BEAT: begin
            for (int i = 0; i < 8; i++)
               if (BEAT_KINDS[i] == value) code = BEAT_BASE + 6'(i);
         end
         lpkc_pkg::CLASS_STATUS: begin
            for (int i = 0; i < 13; i++)
               if (STATUS_KINDS[i] == value) code = STATUS_BASE + 6'(i);
         end
         lpkc_pkg::CLASS_AUDIO: begin
            for (int i = 0; i < 3; i++)
               if (AUDIO_KINDS[i] == value) code = AUDIO_BASE + 6'(i);
         end
         default: code = lpkc_pkg::KIND_UNKNOWN;
      endcase
      return code;
   endfunction

   task automatic clear_packet();
      byte_count  = '0;
      prefix_ok   = 1'b1;
      frame_class = lpkc_pkg::CLASS_NONE;
      kind_byte   = '0;
      kind_seen   = 1'b0;
      device_byte = '0;
      device_seen = 1'b0;
   endtask

   // Advance the packet state by one beat; queue a result on the last byte
   task automatic absorb_byte(lpkc_pkg::req_type beat);
      logic [5:0]        pos;
      logic [5:0]        next_count;
      logic [5:0]        device_at;
      lpkc_pkg::rsp_type result;
      pos = byte_count;
      if (pos == 6'd0) frame_class = class_for(beat.dest_port);
      if (pos < lpkc_pkg::PREFIX_END &&
          beat.data_byte != lpkc_pkg::PREFIX_BYTES[pos]) prefix_ok = 1'b0;
      if (pos == lpkc_pkg::KIND_AT) begin
         kind_byte = beat.data_byte;
         kind_seen = 1'b1;
      end
      device_at = (frame_class == lpkc_pkg::CLASS_ANNOUNCE) ? lpkc_pkg::NUM_AT_ANNOUNCE
                                                            : lpkc_pkg::NUM_AT_OTHER;
      if (pos == device_at) begin
         device_byte = beat.data_byte;
         device_seen = 1'b1;
      end
      // count saturates so very long packets only wait for the last mark
      next_count = (pos >= lpkc_pkg::POS_LIMIT) ? lpkc_pkg::POS_LIMIT : pos + 6'd1;
      if (!beat.last_byte) begin
         byte_count = next_count;
      end else begin
         result.magic_match   = prefix_ok && (next_count >= lpkc_pkg::PREFIX_END);
         result.packet_kind   = (result.magic_match && kind_seen) ?
                                kind_for(frame_class, kind_byte) : lpkc_pkg::KIND_UNKNOWN;
         result.device_number = device_seen ? device_byte : 8'h00;
         result.number_valid  = device_seen;
         expected_results.push_back(result);
         clear_packet();
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Watch all three channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         announce_port = lpkc_pkg::ANNOUNCE_PORT_RESET;
         beat_port     = lpkc_pkg::BEAT_PORT_RESET;
         status_port   = lpkc_pkg::STATUS_PORT_RESET;
         audio_port    = lpkc_pkg::AUDIO_PORT_RESET;
         clear_packet();
         expected_results.delete();
      end else begin
         // a beat taken at this edge still sees the old port registers
         if (req_valid && !req_stall) absorb_byte(req_data);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lpkc_pkg::CSR_ANNOUNCE_PORT: announce_port = csr_data;
               lpkc_pkg::CSR_BEAT_PORT:     beat_port     = csr_data;
               lpkc_pkg::CSR_STATUS_PORT:   status_port   = csr_data;
               lpkc_pkg::CSR_AUDIO_PORT:    audio_port    = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               wanted = expected_results.pop_front();
               check_field("packet_kind", 8'(wanted.packet_kind), 8'(rsp_data.packet_kind));
               check_field("device_number", wanted.device_number, rsp_data.device_number);
               check_field("number_valid", 8'(wanted.number_valid),
                           8'(rsp_data.number_valid));
               check_field("magic_match", 8'(wanted.magic_match), 8'(rsp_data.magic_match));
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// ----- tb/link_packet_kind_classifier_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// link_packet_kind_classifier_top_tb: stimulus and verdict for the classifier
// Streams directed and random packets through several port register settings
// with random idle and stall cycles; the kind checker scores the results.
// ----------------------------------------------------------------------------
module link_packet_kind_classifier_top_tb;

   localparam int BYTE_TARGET   = 630;
   localparam int SETTING_COUNT = 6;
   localparam int MIN_PACKETS   = 3;

   // Every kind byte that some class recognizes
   localparam logic [0:27][7:0] KNOWN_KIND_BYTES = {
      8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h08, 8'h0a, 8'h0b,
      8'h26, 8'h27, 8'h28, 8'h2a, 8'h6a, 8'h10, 8'h19, 8'h1a, 8'h29, 8'h34,
      8'h39, 8'h40, 8'h55, 8'h56, 8'h58, 8'h1e, 8'h1f, 8'h20
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   lpkc_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   lpkc_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_index = '0;
   logic [15:0]       csr_data  = '0;

   bit                steady    = 1'b0;
   int                bytes_sent;
   int                packets_sent;
   int                mismatch_count;
   int                outstanding;
   logic [15:0]       port_setting [4] = '{lpkc_pkg::ANNOUNCE_PORT_RESET,
                                           lpkc_pkg::BEAT_PORT_RESET,
                                           lpkc_pkg::STATUS_PORT_RESET,
                                           lpkc_pkg::AUDIO_PORT_RESET};

   link_packet_kind_classifier_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   lpkc_kind_checker i_kind_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stall result beats at random unless in a steady stretch
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 35);
   end

   // Offer one beat, with an optional idle gap first, and hold it until taken
   task automatic send_byte(input logic [7:0] value, input logic [15:0] port,
                            input logic last);
      lpkc_pkg::req_type beat;
      if (!steady && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      beat.data_byte = value;
      beat.dest_port = port;
      beat.last_byte = last;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Send a packet with the magic prefix, a kind byte and random filler;
   // corrupt the byte at bad_at when it lies inside the packet
   task automatic send_packet(input int len, input logic [15:0] port,
                              input logic [7:0] kind_value, input int bad_at);
      logic [7:0] value;
      for (int i = 0; i < len; i++) begin
         if (i < lpkc_pkg::PREFIX_LEN) value = lpkc_pkg::PREFIX_BYTES[i];
         else if (i == lpkc_pkg::KIND_AT) value = kind_value;
         else value = 8'($urandom);
         if (i == bad_at) value ^= 8'($urandom_range(1, 255));
         send_byte(value, (i == 0) ? port : 16'($urandom), i == len - 1);
      end
      packets_sent++;
   endtask

   task automatic send_random_packet();
      int          len;
      int          pick;
      int          bad_at;
      logic [15:0] port;
      logic [7:0]  kind_value;
      pick = $urandom_range(9);
      if (pick < 8) port = port_setting[pick / 2];
      else port = 16'($urandom);
      // mostly short packets and ones that reach the device number byte
      pick = $urandom_range(9);
      if (pick < 3) len = $urandom_range(1, 12);
      else if (pick < 7) len = $urandom_range(33, 38);
      else if (pick < 9) len = $urandom_range(13, 32);
      else len = $urandom_range(39, 70);
      if ($urandom_range(9) < 7) kind_value = KNOWN_KIND_BYTES[$urandom_range(27)];
      else kind_value = 8'($urandom);
      bad_at = -1;
      if ($urandom_range(4) == 0) bad_at = $urandom_range(9);
      send_packet(len, port, kind_value, bad_at);
   endtask

   task automatic write_reg(input logic [7:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (index <= lpkc_pkg::CSR_AUDIO_PORT) port_setting[index[1:0]] = value;
   endtask

   task automatic program_ports(input logic [15:0] announce, input logic [15:0] beat,
                                input logic [15:0] status, input logic [15:0] audio);
      write_reg(lpkc_pkg::CSR_ANNOUNCE_PORT, announce);
      write_reg(lpkc_pkg::CSR_BEAT_PORT, beat);
      write_reg(lpkc_pkg::CSR_STATUS_PORT, status);
      write_reg(lpkc_pkg::CSR_AUDIO_PORT, audio);
   endtask

   // Drop valid, wait for every result, then let the output register settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int          start_bytes;
      int          start_packets;
      logic [15:0] shared;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, exact ten-byte magic, a recognized kind
      send_byte(8'hff, 16'hffff, 1'b1);
      send_byte(8'h00, 16'h0000, 1'b1);
      send_packet(10, lpkc_pkg::BEAT_PORT_RESET, 8'h00, -1);
      send_packet(11, lpkc_pkg::STATUS_PORT_RESET, 8'h58, -1);
      drain();

      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         shared = 16'($urandom);
         case (setting)
            1: program_ports(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            2: program_ports(16'hffff, 16'hffff, 16'hffff, 16'hffff);
            3: program_ports(16'($urandom), shared, shared, shared);
            4: begin
               program_ports(16'h0000, 16'h0000, 16'h0000, 16'h0000);
               // out-of-range indexes must leave the ports alone
               write_reg(8'd4, 16'($urandom));
               write_reg(8'hff, 16'($urandom));
            end
            5: program_ports(16'($urandom), 16'($urandom), shared, shared);
            default: ;
         endcase
         // one whole setting runs without idles on either side
         steady = (setting == 1);
         start_bytes   = bytes_sent;
         start_packets = packets_sent;
         while (bytes_sent - start_bytes < BYTE_TARGET / SETTING_COUNT ||
                packets_sent - start_packets < MIN_PACKETS)
            send_random_packet();
         drain();
      end

      if (mismatch_count == 0 && outstanding == 0) begin
         $display("[link_packet_kind_classifier_top] OK");
      end else begin
         if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
         $display("[link_packet_kind_classifier_top] ERROR");
      end
      $finish;
   end

   // Give up long after the slowest correct run would have ended
   initial begin
      #10_000_000;
      $display("[link_packet_kind_classifier_top] ERROR");
      $finish;
   end

endmodule
